FILE: src/rdi_pkg.sv
// ----------------------------------------------------------------------------
// rdi_pkg - shared types and codes for the relay direction interlock
// Operation, direction and status codes, register indexes and the result
// word that passes from the interlock core to the output register.
// ----------------------------------------------------------------------------
package rdi_pkg;

    localparam int unsigned HOLD_BITS_DEF      = 16;
    localparam int unsigned DEAD_TIME_BITS_DEF = 10;

    // Fixed field widths of the words on the channels and the config port
    localparam int unsigned OP_W     = 2;
    localparam int unsigned DIR_W    = 2;
    localparam int unsigned HOLD_W   = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 10;

    typedef enum logic [OP_W-1:0] {
        OP_TICK         = 2'd0,
        OP_START        = 2'd1,
        OP_STOP         = 2'd2,
        OP_TAKE_TIMEOUT = 2'd3
    } t_op;

    localparam logic [DIR_W-1:0] DIR_STOP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP      = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN    = 2'd2;
    localparam logic [DIR_W-1:0] DIR_INVALID = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_STARTED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EXTENDED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_SWITCHED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TIME  = 1'd1;

    typedef struct packed {
        logic [STATUS_W-1:0] start_status;
        logic                was_moving;
        logic                timeout_seen;
        logic [DIR_W-1:0]    current_direction;
        logic                up_pin_level;
        logic                down_pin_level;
    } t_result;

endpackage

FILE: src/rdi_if.sv
// ----------------------------------------------------------------------------
// rdi_cmd_if / rdi_res_if - valid/ready channels of the interlock
// One command word in, one result word out; a word moves when valid and
// ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface rdi_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [1:0]  direction_request;
    logic [15:0] hold_ms;

    modport source (output valid, output operation, output direction_request,
                    output hold_ms, input ready);
    modport sink   (input valid, input operation, input direction_request,
                    input hold_ms, output ready);
endinterface

interface rdi_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] start_status;
    logic       was_moving;
    logic       timeout_seen;
    logic [1:0] current_direction;
    logic       up_pin_level;
    logic       down_pin_level;

    modport source (output valid, output start_status, output was_moving,
                    output timeout_seen, output current_direction,
                    output up_pin_level, output down_pin_level, input ready);
    modport sink   (input valid, input start_status, input was_moving,
                    input timeout_seen, input current_direction,
                    input up_pin_level, input down_pin_level, output ready);
endinterface

FILE: src/rdi_core.sv
// ----------------------------------------------------------------------------
// rdi_core - direction, hold and dead-time state of the interlock
// Holds the motor state and works out the result word of one command in
// a single pass; the state advances on every accepted word.
// ----------------------------------------------------------------------------
module rdi_core
    import rdi_pkg::*;
#(
    parameter int unsigned HOLD_BITS      = HOLD_BITS_DEF,
    parameter int unsigned DEAD_TIME_BITS = DEAD_TIME_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [OP_W-1:0]           i_operation,
    input  logic [DIR_W-1:0]          i_direction_request,
    input  logic [HOLD_W-1:0]         i_hold_ms,
    input  logic                      i_active_low,
    input  logic [DEAD_TIME_BITS-1:0] i_dead_time,
    output t_result                   o_result
);

    localparam int unsigned HW = (HOLD_BITS > HOLD_W) ? HOLD_BITS : HOLD_W;
    localparam logic [HW-1:0] HOLD_MAX = HW'((64'd1 << HOLD_BITS) - 64'd1);

    logic [DIR_W-1:0]          r_dir,   n_dir;
    logic [HOLD_BITS-1:0]      r_hold,  n_hold;
    logic                      r_armed, n_armed;
    logic [DEAD_TIME_BITS-1:0] r_dead,  n_dead;
    logic                      r_tpend, n_tpend;

    logic [HW-1:0]        hold_ext;
    logic [HOLD_BITS-1:0] hold_sat;
    logic [DIR_W-1:0]     req;
    t_op                  op;

    assign op       = t_op'(i_operation);
    assign req      = (i_direction_request == DIR_INVALID) ? DIR_STOP : i_direction_request;
    assign hold_ext = HW'(i_hold_ms);
    assign hold_sat = (hold_ext > HOLD_MAX) ? HOLD_MAX[HOLD_BITS-1:0]
                                            : hold_ext[HOLD_BITS-1:0];

    always_comb begin
        n_dir   = r_dir;
        n_hold  = r_hold;
        n_armed = r_armed;
        n_dead  = r_dead;
        n_tpend = r_tpend;
        o_result = '0;
        unique case (op)
            OP_TICK: begin
                // dead time runs first, hold countdown after it
                if (r_dead != '0) begin
                    n_dead = r_dead - DEAD_TIME_BITS'(1);
                end else if (r_armed) begin
                    if (r_hold <= HOLD_BITS'(1)) begin
                        n_hold  = '0;
                        n_armed = 1'b0;
                        n_dir   = DIR_STOP;
                        n_tpend = 1'b1;
                    end else begin
                        n_hold = r_hold - HOLD_BITS'(1);
                    end
                end
            end
            OP_START: begin
                if (r_dir == req) begin
                    o_result.start_status = STATUS_EXTENDED;
                end else begin
                    n_dead  = (r_dir != DIR_STOP && req != DIR_STOP) ? i_dead_time : '0;
                    n_dir   = req;
                    n_tpend = 1'b0;
                    o_result.start_status = (r_dir == DIR_STOP) ? STATUS_STARTED
                                                                : STATUS_SWITCHED;
                end
                n_hold  = hold_sat;
                n_armed = 1'b1;
            end
            OP_STOP: begin
                o_result.was_moving = (r_dir != DIR_STOP);
                n_armed = 1'b0;
                n_dead  = '0;
                n_dir   = DIR_STOP;
                n_tpend = 1'b0;
            end
            OP_TAKE_TIMEOUT: begin
                o_result.timeout_seen = r_tpend;
                n_tpend = 1'b0;
            end
        endcase
        o_result.current_direction = n_dir;
        o_result.up_pin_level   = (n_dir == DIR_UP   && n_dead == '0) ^ i_active_low;
        o_result.down_pin_level = (n_dir == DIR_DOWN && n_dead == '0) ^ i_active_low;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= DIR_STOP;
            r_hold  <= '0;
            r_armed <= 1'b0;
            r_dead  <= '0;
            r_tpend <= 1'b0;
        end else if (i_accept) begin
            r_dir   <= n_dir;
            r_hold  <= n_hold;
            r_armed <= n_armed;
            r_dead  <= n_dead;
            r_tpend <= n_tpend;
        end
    end

endmodule

FILE: src/relay_direction_interlock.sv
// ----------------------------------------------------------------------------
// relay_direction_interlock - up/down motor relay interlock with dead time
// The result word of an accepted command word is registered in the result register.
// Throughput: one word per cycle while the receiver keeps ready high; the single
// result register takes a new word in the cycle its current word is taken, set by the one-pass core.
// Reset (synchronous, active low): relays off, stopped, timers disarmed,
// no pending timeout, active_low = 1, dead time = 50 ticks.
// ----------------------------------------------------------------------------
module relay_direction_interlock
    import rdi_pkg::*;
#(
    parameter int unsigned HOLD_BITS      = HOLD_BITS_DEF,
    parameter int unsigned DEAD_TIME_BITS = DEAD_TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rdi_cmd_if.sink               i_cmd,
    rdi_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned DW = (DEAD_TIME_BITS > CFG_DATA_W) ? DEAD_TIME_BITS : CFG_DATA_W;
    localparam logic [DW-1:0] DEAD_MAX = DW'((64'd1 << DEAD_TIME_BITS) - 64'd1);
    localparam logic [DW-1:0] DEAD_RST = DW'(50);

    // Configuration registers
    logic                      r_active_low;
    logic [DEAD_TIME_BITS-1:0] r_dead_time;
    logic [DW-1:0]             cfg_ext;
    logic [DEAD_TIME_BITS-1:0] cfg_dead_sat;
    logic [DEAD_TIME_BITS-1:0] dead_rst_sat;

    // Result register and handshake
    logic    r_res_valid;
    t_result r_res;
    t_result core_res;
    logic    cmd_accept;

    // Saturate the written dead time to the counter width
    assign cfg_ext      = DW'(i_cfg_data);
    assign cfg_dead_sat = (cfg_ext > DEAD_MAX) ? DEAD_MAX[DEAD_TIME_BITS-1:0]
                                               : cfg_ext[DEAD_TIME_BITS-1:0];
    assign dead_rst_sat = (DEAD_RST > DEAD_MAX) ? DEAD_MAX[DEAD_TIME_BITS-1:0]
                                                : DEAD_RST[DEAD_TIME_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_low <= 1'b1;
            r_dead_time  <= dead_rst_sat;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ACTIVE_LOW: r_active_low <= i_cfg_data[0];
                CFG_DEAD_TIME:  r_dead_time  <= cfg_dead_sat;
                default: begin
                end
            endcase
        end
    end

    // Take a new word whenever the result register is empty or being drained
    assign i_cmd.ready = !r_res_valid || o_res.ready;
    assign cmd_accept  = i_cmd.valid && i_cmd.ready;

    rdi_core #(
        .HOLD_BITS      (HOLD_BITS),
        .DEAD_TIME_BITS (DEAD_TIME_BITS)
    ) u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (cmd_accept),
        .i_operation         (i_cmd.operation),
        .i_direction_request (i_cmd.direction_request),
        .i_hold_ms           (i_cmd.hold_ms),
        .i_active_low        (r_active_low),
        .i_dead_time         (r_dead_time),
        .o_result            (core_res)
    );

    // Hold the result word until it is taken; load a fresh one on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (cmd_accept) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_accept) begin
            r_res <= core_res;
        end
    end

    assign o_res.valid             = r_res_valid;
    assign o_res.start_status      = r_res.start_status;
    assign o_res.was_moving        = r_res.was_moving;
    assign o_res.timeout_seen      = r_res.timeout_seen;
    assign o_res.current_direction = r_res.current_direction;
    assign o_res.up_pin_level      = r_res.up_pin_level;
    assign o_res.down_pin_level    = r_res.down_pin_level;

    // Break-before-make: never both relays energised in one result word
    a_no_double_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_accept |-> !((core_res.up_pin_level ^ r_active_low) &&
                         (core_res.down_pin_level ^ r_active_low)))
        else $error("both relays energised");

    // An accepted word shows up as a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_accept |=> o_res.valid)
        else $error("accepted word produced no result");

    // Only a start reports a start status
    a_status_only_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_accept && t_op'(i_cmd.operation) != OP_START) |=>
            (o_res.start_status == STATUS_NONE))
        else $error("start status on a non-start word");

endmodule

FILE: tb/tb_relay_direction_interlock.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_relay_direction_interlock - self-checking bench for the relay interlock
// Walks a short table of commands, then random start/tick/stop/query runs
// under several polarity and dead-time settings. A predictor in the bench
// mirrors the interlock and every result word is checked field by field.
// ----------------------------------------------------------------------------
module tb_relay_direction_interlock;
    import rdi_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;  // far beyond the slowest legal run
    localparam int DRAIN_CYCLES  = 4;       // a margin past the result register
    localparam int PHASE_WORDS   = 230;
    localparam int LONG_STALL    = 80;
    localparam int DIRECTED_ROWS = 24;

    // One row of the directed table: command fields plus an optional
    // hand-written result; rows without one fall back on the predictor.
    typedef struct packed {
        t_op           op;
        logic [1:0]    dir;
        logic [15:0]   hold;
        logic          typed;
        t_result       want;
    } t_cmd_row;

    // Idle levels after reset: stopped, active_low = 1, so both pins high
    localparam t_result IDLE_RES  = {STATUS_NONE, 1'b0, 1'b0, DIR_STOP, 1'b1, 1'b1};
    localparam t_result UP_START  = {STATUS_NONE | STATUS_STARTED, 1'b0, 1'b0, DIR_UP,
                                     1'b0, 1'b1};
    localparam t_result DN_START  = {STATUS_STARTED, 1'b0, 1'b0, DIR_DOWN, 1'b1, 1'b0};
    localparam t_result UP_SWITCH = {STATUS_SWITCHED, 1'b0, 1'b0, DIR_UP, 1'b1, 1'b1};
    localparam t_result UNTYPED   = '0;

    localparam t_cmd_row DIRECTED [DIRECTED_ROWS] = '{
        // query, stop and tick straight after reset
        {OP_TAKE_TIMEOUT, DIR_STOP,    16'd0,      1'b1, IDLE_RES},
        {OP_STOP,         DIR_STOP,    16'd0,      1'b1, IDLE_RES},
        {OP_TICK,         DIR_STOP,    16'd0,      1'b1, IDLE_RES},
        // start up, extend, then run the hold out to a timeout
        {OP_START,        DIR_UP,      16'd3,      1'b1, UP_START},
        {OP_START,        DIR_UP,      16'd2,      1'b0, UNTYPED},
        {OP_TICK,         DIR_STOP,    16'd0,      1'b0, UNTYPED},
        {OP_TICK,         DIR_INVALID, 16'hFFFF,   1'b0, UNTYPED},
        {OP_TAKE_TIMEOUT, DIR_STOP,    16'd0,      1'b0, UNTYPED},
        {OP_TAKE_TIMEOUT, DIR_DOWN,    16'hFFFF,   1'b0, UNTYPED},
        // longest hold, then a reversal into the dead time
        {OP_START,        DIR_DOWN,    16'hFFFF,   1'b1, DN_START},
        {OP_START,        DIR_UP,      16'd5,      1'b1, UP_SWITCH},
        {OP_TICK,         DIR_STOP,    16'd0,      1'b0, UNTYPED},
        // reverse again while the dead time is still running, then stop
        {OP_START,        DIR_DOWN,    16'd0,      1'b0, UNTYPED},
        {OP_STOP,         DIR_UP,      16'd9,      1'b0, UNTYPED},
        // invalid direction counts as stop: arms a timer while stopped
        {OP_START,        DIR_INVALID, 16'd0,      1'b0, UNTYPED},
        {OP_TICK,         DIR_STOP,    16'd0,      1'b0, UNTYPED},
        {OP_TAKE_TIMEOUT, DIR_STOP,    16'd0,      1'b0, UNTYPED},
        // zero hold expires on the first tick
        {OP_START,        DIR_UP,      16'd0,      1'b0, UNTYPED},
        {OP_TICK,         DIR_STOP,    16'd0,      1'b0, UNTYPED},
        // a fresh start clears the pending timeout
        {OP_START,        DIR_DOWN,    16'd1,      1'b0, UNTYPED},
        {OP_TAKE_TIMEOUT, DIR_STOP,    16'd0,      1'b0, UNTYPED},
        // start with stop while moving: switched, no dead time
        {OP_START,        DIR_STOP,    16'd1,      1'b0, UNTYPED},
        {OP_STOP,         DIR_STOP,    16'd0,      1'b0, UNTYPED},
        {OP_TICK,         DIR_DOWN,    16'h5A5A,   1'b0, UNTYPED}
    };

    logic i_clk;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rdi_cmd_if cmd ();
    rdi_res_if res ();

    relay_direction_interlock uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_res       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Mirror of the interlock state and its two registers
    logic [1:0]  dir_now;
    logic [15:0] hold_left;
    logic        hold_on;
    logic [9:0]  dead_left;
    logic        timeout_flag;
    logic        cfg_active_low;
    logic [9:0]  cfg_dead;

    t_result expected_words [$];

    int n_errors;
    int n_checked;
    int n_sent;
    int n_settings;
    int n_reversals;
    int n_expiries;
    int cycle_count;

    // Idle percentages for each side, and the request for one long hold-off
    int snd_idle;
    int rcv_idle;
    bit stall_req;
    int stall_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Work out the result word of one command and advance the mirrored state.
    function automatic t_result predict_relay_word(t_op op, logic [1:0] dir_req,
                                                   logic [15:0] hold);
        t_result    r;
        logic [1:0] req;
        logic [1:0] prev;
        r    = '0;
        req  = (dir_req == DIR_INVALID) ? DIR_STOP : dir_req;
        prev = dir_now;
        case (op)
            OP_TICK: begin
                // dead time runs first; the hold only counts once it is over
                if (dead_left != '0) begin
                    dead_left = dead_left - 10'd1;
                end else if (hold_on) begin
                    if (hold_left <= 16'd1) begin
                        hold_left    = '0;
                        hold_on      = 1'b0;
                        dir_now      = DIR_STOP;
                        timeout_flag = 1'b1;
                        n_expiries++;
                    end else begin
                        hold_left = hold_left - 16'd1;
                    end
                end
            end
            OP_START: begin
                if (prev == req) begin
                    r.start_status = STATUS_EXTENDED;
                end else begin
                    // break before make only on a true reversal
                    if (prev != DIR_STOP && req != DIR_STOP) begin
                        dead_left = cfg_dead;
                        n_reversals++;
                    end else begin
                        dead_left = '0;
                    end
                    dir_now        = req;
                    timeout_flag   = 1'b0;
                    r.start_status = (prev == DIR_STOP) ? STATUS_STARTED : STATUS_SWITCHED;
                end
                hold_left = hold;
                hold_on   = 1'b1;
            end
            OP_STOP: begin
                r.was_moving = (prev != DIR_STOP);
                hold_on      = 1'b0;
                dead_left    = '0;
                dir_now      = DIR_STOP;
                timeout_flag = 1'b0;
            end
            default: begin
                r.timeout_seen = timeout_flag;
                timeout_flag   = 1'b0;
            end
        endcase
        r.current_direction = dir_now;
        r.up_pin_level   = ((dir_now == DIR_UP) && (dead_left == '0)) ^ cfg_active_low;
        r.down_pin_level = ((dir_now == DIR_DOWN) && (dead_left == '0)) ^ cfg_active_low;
        return r;
    endfunction

    // Offer one command word, hold it until taken, then queue its result.
    // A typed row queues the hand-written word; the mirror advances anyway.
    task automatic send_word(t_op op, logic [1:0] dir, logic [15:0] hold,
                             logic typed, t_result want);
        t_result pred;
        while ($urandom_range(0, 99) < snd_idle) begin
            cmd.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd.valid             <= 1'b1;
        cmd.operation         <= op;
        cmd.direction_request <= dir;
        cmd.hold_ms           <= hold;
        @(posedge i_clk);
        while (!cmd.ready) @(posedge i_clk);
        pred = predict_relay_word(op, dir, hold);
        expected_words.push_back(typed ? want : pred);
        n_sent++;
    endtask

    // Drop valid and wait until every result word is home, plus a margin.
    task automatic settle_idle;
        cmd.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers on back-to-back edges, keeping the enable high.
    task automatic write_regs(logic al, logic [9:0] dead);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ACTIVE_LOW;
        cfg_data  <= {9'd0, al};
        @(posedge i_clk);
        cfg_active_low = al;
        cfg_index <= CFG_DEAD_TIME;
        cfg_data  <= dead;
        @(posedge i_clk);
        cfg_dead = dead;
        cfg_we   <= 1'b0;
        n_settings++;
    endtask

    // Mostly a start followed by a run of mostly ticks that can reach the
    // end of the dead time and the hold; the rest is unshaped noise.
    // The run of ticks is kept within what is left of the phase budget.
    task automatic drive_random_sequence(int budget);
        int          pick;
        int          burst;
        int          span;
        logic [1:0]  dir;
        logic [15:0] hold;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            dir  = ($urandom_range(0, 4) != 0) ? 2'($urandom_range(1, 2))
                                               : 2'($urandom_range(0, 3));
            hold = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
            send_word(OP_START, dir, hold, 1'b0, UNTYPED);
            span  = (int'(hold) > 1100) ? 1100 : int'(hold);
            burst = $urandom_range(0, span + int'(cfg_dead) + 2);
            if (burst > 64 && $urandom_range(0, 7) != 0) burst = $urandom_range(0, 64);
            if (burst > budget) burst = budget;
            for (int k = 0; k < burst; k++) begin
                pick = $urandom_range(0, 11);
                if (pick == 0) begin
                    send_word(OP_START, dir, 16'($urandom_range(0, 20)), 1'b0, UNTYPED);
                end else if (pick == 1) begin
                    send_word(OP_TAKE_TIMEOUT, 2'($urandom_range(0, 3)), 16'($urandom),
                              1'b0, UNTYPED);
                end else begin
                    send_word(OP_TICK, 2'($urandom_range(0, 3)), 16'($urandom),
                              1'b0, UNTYPED);
                end
            end
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                send_word(OP_TAKE_TIMEOUT, DIR_STOP, 16'($urandom), 1'b0, UNTYPED);
            end else if (pick < 7) begin
                send_word(OP_STOP, 2'($urandom_range(0, 3)), 16'($urandom), 1'b0, UNTYPED);
            end
        end else begin
            send_word(t_op'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                      16'($urandom), 1'b0, UNTYPED);
        end
    endtask

    // One setting of the registers and one idling pattern, for a budget of words
    task automatic run_phase(logic al, logic [9:0] dead, int snd, int rcv, bit squeeze);
        int start;
        settle_idle();
        write_regs(al, dead);
        snd_idle = snd;
        rcv_idle = rcv;
        if (squeeze) stall_req = 1'b1;
        start = n_sent;
        while (n_sent - start < PHASE_WORDS) begin
            drive_random_sequence(PHASE_WORDS - (n_sent - start));
        end
    endtask

    // Receiver: random ready, or a long hold-off when asked for one, so the
    // result register fills and the command side backs up behind it.
    initial res.ready = 1'b0;
    always @(posedge i_clk) begin
        if (stall_req) begin
            stall_left = LONG_STALL;
            stall_req  = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            res.ready <= 1'b0;
        end else begin
            res.ready <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    // Check each taken result word against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res.valid && res.ready) begin
            if (expected_words.size() == 0) begin
                $error("result word taken with nothing expected");
                n_errors++;
            end else begin
                want = expected_words.pop_front();
                n_checked++;
                if (res.start_status !== want.start_status) begin
                    $error("start_status: expected %0d, actual %0d",
                           want.start_status, res.start_status);
                    n_errors++;
                end
                if (res.was_moving !== want.was_moving) begin
                    $error("was_moving: expected %0d, actual %0d",
                           want.was_moving, res.was_moving);
                    n_errors++;
                end
                if (res.timeout_seen !== want.timeout_seen) begin
                    $error("timeout_seen: expected %0d, actual %0d",
                           want.timeout_seen, res.timeout_seen);
                    n_errors++;
                end
                if (res.current_direction !== want.current_direction) begin
                    $error("current_direction: expected %0d, actual %0d",
                           want.current_direction, res.current_direction);
                    n_errors++;
                end
                if (res.up_pin_level !== want.up_pin_level) begin
                    $error("up_pin_level: expected %0d, actual %0d",
                           want.up_pin_level, res.up_pin_level);
                    n_errors++;
                end
                if (res.down_pin_level !== want.down_pin_level) begin
                    $error("down_pin_level: expected %0d, actual %0d",
                           want.down_pin_level, res.down_pin_level);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: drop the run if it hangs on a handshake
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_words.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        // Drive every input to a known level from time zero
        i_rst_n               <= 1'b0;
        cmd.valid             <= 1'b0;
        cmd.operation         <= OP_TICK;
        cmd.direction_request <= DIR_STOP;
        cmd.hold_ms           <= '0;
        cfg_we                <= 1'b0;
        cfg_index             <= CFG_ACTIVE_LOW;
        cfg_data              <= '0;
        stall_req   = 1'b0;
        stall_left  = 0;
        n_errors    = 0;
        n_checked   = 0;
        n_sent      = 0;
        n_settings  = 0;
        n_reversals = 0;
        n_expiries  = 0;
        cycle_count = 0;
        snd_idle    = 38;
        rcv_idle    = 83;

        // Mirror the reset state
        dir_now        = DIR_STOP;
        hold_left      = '0;
        hold_on        = 1'b0;
        dead_left      = '0;
        timeout_flag   = 1'b0;
        cfg_active_low = 1'b1;
        cfg_dead       = 10'd50;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under the reset settings
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_word(DIRECTED[i].op, DIRECTED[i].dir, DIRECTED[i].hold,
                      DIRECTED[i].typed, DIRECTED[i].want);
        end

        // Random runs: sender idles lightly first, then the receiver does,
        // then neither; extremes of both registers on the way.
        run_phase(1'b0, 10'd0,    38, 83, 1'b0);
        run_phase(1'b1, 10'd1023, 38, 83, 1'b0);
        run_phase(1'b0, 10'd3,    83, 38, 1'b0);
        run_phase(1'b1, 10'd1,    83, 38, 1'b0);
        run_phase(1'b0, 10'd9,     0,  0, 1'b1);
        run_phase(1'b1, 10'($urandom_range(0, 1023)), 0, 0, 1'b0);

        settle_idle();

        $display("covered %0d command words under %0d register settings with both sides idling",
                 n_sent, n_settings);
        $display("%0d words checked, %0d reversals through dead time, %0d hold expiries",
                 n_checked, n_reversals, n_expiries);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: relay_direction_interlock.f
src/rdi_pkg.sv
src/rdi_if.sv
src/rdi_core.sv
src/relay_direction_interlock.sv
tb/tb_relay_direction_interlock.sv
